/* sv/sdte_pkg.sv */
package sdte_pkg;

  localparam int TEXT_LENGTH = 20;
  localparam int IDX_W = 5;
  localparam int POS_W = 7;

  localparam logic [2:0][7:0] SCR = {8'h93, 8'h4F, 8'h70};
  localparam logic [7:0] FILLER = 8'h66;
  localparam logic [7:0] SYNC_BYTE = 8'h55;
  localparam logic [7:0] SPACE = 8'h20;
  localparam logic [3:0] TYPE_HDR = 4'h5;
  localparam logic [3:0] TYPE_TXT = 4'h4;
  localparam int LAST_FLAG_BIT = 6;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_CHAR = 1'b1;

  typedef logic [2:0][7:0] sdte_bytes_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] pos;
    logic [7:0]       data;
  } sdte_wr_t;

  typedef sdte_wr_t [2:0] sdte_wr_set_t;

  typedef struct packed {
    logic             kind;
    logic [7:0]       slow_out0;
    logic [7:0]       slow_out1;
    logic [7:0]       slow_out2;
    logic [15:0]      frame_count;
    logic             send_initial;
    logic             stream_end;
    logic [7:0]       text_char;
    logic [IDX_W-1:0] text_index;
    logic             last;
  } sdte_result_t;

endpackage

/* sv/sdte_in_if.sv */
interface sdte_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_number;
  logic [7:0] slow_in0;
  logic [7:0] slow_in1;
  logic [7:0] slow_in2;

  modport source (output valid, frame_number, slow_in0, slow_in1, slow_in2, input ready);
  modport sink (input valid, frame_number, slow_in0, slow_in1, slow_in2, output ready);
endinterface

/* sv/sdte_out_if.sv */
interface sdte_out_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [7:0]                    slow_out0;
  logic [7:0]                    slow_out1;
  logic [7:0]                    slow_out2;
  logic [15:0]                   frame_count;
  logic                          send_initial;
  logic                          stream_end;
  logic [7:0]                    text_char;
  logic [sdte_pkg::IDX_W-1:0]    text_index;
  logic                          last;

  modport source (output valid, kind, slow_out0, slow_out1, slow_out2, frame_count,
                  send_initial, stream_end, text_char, text_index, last, input ready);
  modport sink (input valid, kind, slow_out0, slow_out1, slow_out2, frame_count,
                send_initial, stream_end, text_char, text_index, last, output ready);
endinterface

/* sv/sdte_descramble.sv */
module sdte_descramble (
  input  logic [7:0]             frame_number,
  input  sdte_pkg::sdte_bytes_t  slow_in,
  input  logic [7:0]             header,
  output logic [7:0]             header_next,
  output sdte_pkg::sdte_bytes_t  slow_out,
  output sdte_pkg::sdte_wr_set_t writes
);

  logic                          data_frame;
  logic                          odd;
  logic [sdte_pkg::POS_W-1:0]    base;
  logic [sdte_pkg::POS_W-1:0]    pos [3];

  assign data_frame = |frame_number[4:0];
  assign odd = frame_number[0];
  assign header_next = (data_frame && odd) ? (slow_in[0] ^ sdte_pkg::SCR[0]) : header;
  assign base = {1'b0, header_next[3:0], 2'b00} + {3'b000, header_next[3:0]};

  always_comb begin
    slow_out = slow_in;
    for (int i = 0; i < 3; i++) begin
      if (odd) begin
        pos[i] = base + sdte_pkg::POS_W'(i) - sdte_pkg::POS_W'(1);
      end else begin
        pos[i] = base + sdte_pkg::POS_W'(i) + sdte_pkg::POS_W'(2);
      end
      writes[i].en = 1'b0;
      writes[i].pos = pos[i][sdte_pkg::IDX_W-1:0];
      writes[i].data = slow_in[i] ^ sdte_pkg::SCR[i];
    end
    if (data_frame) begin
      if (header_next[7:4] == sdte_pkg::TYPE_HDR) begin
        for (int i = 0; i < 3; i++) begin
          slow_out[i] = sdte_pkg::FILLER ^ sdte_pkg::SCR[i];
        end
      end else if (header_next[7:4] == sdte_pkg::TYPE_TXT) begin
        for (int i = 0; i < 3; i++) begin
          writes[i].en = (!odd || i != 0)
                         && (pos[i] < sdte_pkg::POS_W'(sdte_pkg::TEXT_LENGTH));
        end
      end
    end
  end

endmodule

/* sv/slow_data_text_extractor.sv */
// A frame result is loaded into the output register at the clock edge of its transfer.
// Throughput: one frame or text character per cycle while the output side keeps up.
// When the frame count reaches PUBLISH_FRAME, the 20 text characters follow the frame
// result one after another, and no frame is taken until the last of them is loaded.
// Reset clears the output valid flag, the frame count and the text run, sets the block
// header to the sync byte and fills the text buffer with spaces.
module slow_data_text_extractor #(
  parameter int PUBLISH_FRAME = 21
) (
  input  logic         clk,
  input  logic         rst,
  sdte_in_if.sink      frame_in,
  sdte_out_if.source   result_out
);

  logic [7:0]                  header;
  logic [7:0]                  header_next;
  logic [7:0]                  message_text [sdte_pkg::TEXT_LENGTH];
  logic [15:0]                 frames_seen;
  logic [15:0]                 frames_seen_next;
  logic                        run_active;
  logic [sdte_pkg::IDX_W-1:0]  run_idx;
  logic                        out_valid;
  sdte_pkg::sdte_result_t      out_res;
  sdte_pkg::sdte_bytes_t       slow_in;
  sdte_pkg::sdte_bytes_t       slow_fwd;
  sdte_pkg::sdte_wr_set_t      writes;
  sdte_pkg::sdte_result_t      frame_res;
  sdte_pkg::sdte_result_t      char_res;
  logic                        out_free;
  logic                        accept;
  logic                        publish;
  logic                        run_done;

  assign slow_in = {frame_in.slow_in2, frame_in.slow_in1, frame_in.slow_in0};

  sdte_descramble u_descramble (
    .frame_number (frame_in.frame_number),
    .slow_in      (slow_in),
    .header       (header),
    .header_next  (header_next),
    .slow_out     (slow_fwd),
    .writes       (writes)
  );

  assign out_free = !out_valid || result_out.ready;
  assign frame_in.ready = !run_active && out_free;
  assign accept = frame_in.valid && frame_in.ready;
  assign frames_seen_next = (frames_seen == 16'hFFFF) ? frames_seen : frames_seen + 16'd1;
  assign publish = (frames_seen != 16'hFFFF) && (frames_seen_next == 16'(PUBLISH_FRAME));
  assign run_done = run_idx == sdte_pkg::IDX_W'(sdte_pkg::TEXT_LENGTH - 1);

  always_comb begin
    frame_res = '0;
    frame_res.kind = sdte_pkg::KIND_FRAME;
    frame_res.slow_out0 = slow_fwd[0];
    frame_res.slow_out1 = slow_fwd[1];
    frame_res.slow_out2 = slow_fwd[2];
    frame_res.frame_count = frames_seen;
    frame_res.send_initial = frames_seen == 16'd0;
    frame_res.stream_end = frame_in.frame_number[sdte_pkg::LAST_FLAG_BIT];
    frame_res.last = !publish;

    char_res = '0;
    char_res.kind = sdte_pkg::KIND_CHAR;
    char_res.text_char = message_text[run_idx];
    char_res.text_index = run_idx;
    char_res.last = run_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      run_active <= 1'b0;
      run_idx <= '0;
      frames_seen <= '0;
      header <= sdte_pkg::SYNC_BYTE;
    end else begin
      if (accept) begin
        header <= header_next;
        frames_seen <= frames_seen_next;
        out_valid <= 1'b1;
        run_active <= publish;
        run_idx <= '0;
      end else if (run_active && out_free) begin
        out_valid <= 1'b1;
        run_idx <= run_idx + sdte_pkg::IDX_W'(1);
        if (run_done) begin
          run_active <= 1'b0;
        end
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_res <= frame_res;
    end else if (run_active && out_free) begin
      out_res <= char_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < sdte_pkg::TEXT_LENGTH; j++) begin
        message_text[j] <= sdte_pkg::SPACE;
      end
    end else if (accept) begin
      for (int i = 0; i < 3; i++) begin
        if (writes[i].en) begin
          message_text[writes[i].pos] <= writes[i].data;
        end
      end
    end
  end

  assign result_out.valid = out_valid;
  assign result_out.kind = out_res.kind;
  assign result_out.slow_out0 = out_res.slow_out0;
  assign result_out.slow_out1 = out_res.slow_out1;
  assign result_out.slow_out2 = out_res.slow_out2;
  assign result_out.frame_count = out_res.frame_count;
  assign result_out.send_initial = out_res.send_initial;
  assign result_out.stream_end = out_res.stream_end;
  assign result_out.text_char = out_res.text_char;
  assign result_out.text_index = out_res.text_index;
  assign result_out.last = out_res.last;

`ifndef ASSERT_OFF
  a_no_take_in_run: assert property (@(posedge clk) disable iff (rst)
    run_active |-> !frame_in.ready)
    else $error("Frame taken during a text run.");

  a_publish_starts_run: assert property (@(posedge clk) disable iff (rst)
    (accept && publish) |=> (run_active && out_valid && !out_res.last))
    else $error("Publishing frame did not start a text run.");

  a_char_index_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.kind == sdte_pkg::KIND_CHAR)
      |-> (out_res.text_index < sdte_pkg::IDX_W'(sdte_pkg::TEXT_LENGTH)))
    else $error("Text index beyond the buffer.");

  a_last_char_ends_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.kind == sdte_pkg::KIND_CHAR && out_res.last) |-> !run_active)
    else $error("Text run still active after its last character.");

  a_count_saturates: assert property (@(posedge clk) disable iff (rst)
    (frames_seen == 16'hFFFF) |=> (frames_seen == 16'hFFFF))
    else $error("Frame count wrapped.");
`endif

endmodule

/* tb/tb_slow_data_text_extractor.sv */
`timescale 1ns / 100ps

class slow_data_tracker;
  logic [7:0]             header;
  logic [7:0]             text [sdte_pkg::TEXT_LENGTH];
  logic [15:0]            frames;
  int                     publish_at;
  int                     errors;
  sdte_pkg::sdte_result_t due [$];

  function new(int at);
    publish_at = at;
    errors = 0;
    header = sdte_pkg::SYNC_BYTE;
    frames = '0;
    foreach (text[i]) text[i] = sdte_pkg::SPACE;
  endfunction

  function void take_frame(logic [7:0] num, sdte_pkg::sdte_bytes_t raw);
    sdte_pkg::sdte_bytes_t  sd;
    logic [15:0]            prior;
    logic                   odd;
    logic                   publish;
    int                     pos;
    int                     first;
    sdte_pkg::sdte_result_t r;
    sd = raw;
    prior = frames;
    if (num[4:0] != 5'd0) begin
      odd = num[0];
      if (odd) begin
        header = sd[0] ^ sdte_pkg::SCR[0];
      end
      if (header[7:4] == sdte_pkg::TYPE_HDR) begin
        for (int i = 0; i < 3; i++) sd[i] = sdte_pkg::FILLER ^ sdte_pkg::SCR[i];
      end else if (header[7:4] == sdte_pkg::TYPE_TXT) begin
        pos = header[3:0] * 5 + (odd ? 0 : 2);
        first = odd ? 1 : 0;
        for (int i = first; i < 3; i++) begin
          if (pos < sdte_pkg::TEXT_LENGTH) text[pos] = sd[i] ^ sdte_pkg::SCR[i];
          pos++;
        end
      end
    end
    if (frames != 16'hFFFF) frames = frames + 16'd1;
    publish = (frames != prior) && (frames == 16'(publish_at));
    r = '0;
    r.kind = sdte_pkg::KIND_FRAME;
    r.slow_out0 = sd[0];
    r.slow_out1 = sd[1];
    r.slow_out2 = sd[2];
    r.frame_count = prior;
    r.send_initial = (prior == 16'd0);
    r.stream_end = num[sdte_pkg::LAST_FLAG_BIT];
    r.last = !publish;
    due.push_back(r);
    if (publish) begin
      for (int i = 0; i < sdte_pkg::TEXT_LENGTH; i++) begin
        r = '0;
        r.kind = sdte_pkg::KIND_CHAR;
        r.text_char = text[i];
        r.text_index = sdte_pkg::IDX_W'(i);
        r.last = (i == sdte_pkg::TEXT_LENGTH - 1);
        due.push_back(r);
      end
    end
  endfunction

  function void diff(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= 200) begin
        $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
      end
    end
  endfunction

  function void check_result(sdte_pkg::sdte_result_t got);
    sdte_pkg::sdte_result_t want;
    if (due.size() == 0) begin
      errors++;
      if (errors <= 200) begin
        $display("%0t: result expected none, actual %h", $time, got);
      end
      return;
    end
    want = due.pop_front();
    diff("kind", 16'(want.kind), 16'(got.kind));
    diff("slow_out0", 16'(want.slow_out0), 16'(got.slow_out0));
    diff("slow_out1", 16'(want.slow_out1), 16'(got.slow_out1));
    diff("slow_out2", 16'(want.slow_out2), 16'(got.slow_out2));
    diff("frame_count", want.frame_count, got.frame_count);
    diff("send_initial", 16'(want.send_initial), 16'(got.send_initial));
    diff("stream_end", 16'(want.stream_end), 16'(got.stream_end));
    diff("text_char", 16'(want.text_char), 16'(got.text_char));
    diff("text_index", 16'(want.text_index), 16'(got.text_index));
    diff("last", 16'(want.last), 16'(got.last));
  endfunction
endclass

module tb_slow_data_text_extractor;
  localparam int PUBLISH_AT = 21;
  localparam int STALL_LIMIT = 1000;
  localparam string MSG = "SLOW DATA TEXT CHECK";

  logic clk;
  logic rst;
  bit calm = 1'b0;
  int unsigned quiet_cycles = 0;
  slow_data_tracker sb;

  sdte_in_if  frame_in ();
  sdte_out_if result_out ();

  slow_data_text_extractor #(
    .PUBLISH_FRAME(PUBLISH_AT)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .frame_in(frame_in),
    .result_out(result_out)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    result_out.ready <= 1'b0;
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        result_out.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        result_out.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : monitor
    sdte_pkg::sdte_result_t seen;
    if (!rst) begin
      if (result_out.valid && result_out.ready) begin
        seen = {result_out.kind, result_out.slow_out0, result_out.slow_out1,
                result_out.slow_out2, result_out.frame_count, result_out.send_initial,
                result_out.stream_end, result_out.text_char, result_out.text_index,
                result_out.last};
        sb.check_result(seen);
      end
      if (frame_in.valid && frame_in.ready) begin
        sb.take_frame(frame_in.frame_number,
                      {frame_in.slow_in2, frame_in.slow_in1, frame_in.slow_in0});
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (frame_in.valid && frame_in.ready)
        || (result_out.valid && result_out.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_frame(input logic [7:0] num, input logic [7:0] b0,
                            input logic [7:0] b1, input logic [7:0] b2);
    if (!calm && $urandom_range(0, 3) == 0) begin
      frame_in.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    frame_in.valid <= 1'b1;
    frame_in.frame_number <= num;
    frame_in.slow_in0 <= b0;
    frame_in.slow_in1 <= b1;
    frame_in.slow_in2 <= b2;
    @(posedge clk);
    while (!frame_in.ready) @(posedge clk);
  endtask

  task automatic send_plain(input logic [7:0] num, input logic [7:0] p0,
                            input logic [7:0] p1, input logic [7:0] p2);
    send_frame(num, p0 ^ sdte_pkg::SCR[0], p1 ^ sdte_pkg::SCR[1], p2 ^ sdte_pkg::SCR[2]);
  endtask

  task automatic send_superframe();
    logic [7:0] num;
    logic [7:0] hdr;
    int pick;
    for (int s = 0; s < 21; s++) begin
      num = 8'(s);
      if ($urandom_range(0, 15) == 0) num[7:5] = 3'($urandom);
      if (s == 20 && $urandom_range(0, 3) == 0) num[sdte_pkg::LAST_FLAG_BIT] = 1'b1;
      pick = $urandom_range(0, 19);
      if (hdr === 8'hxx || s[0]) begin
        if (pick < 12) hdr = {sdte_pkg::TYPE_TXT, 4'($urandom_range(0, 3))};
        else if (pick < 14) hdr = {sdte_pkg::TYPE_TXT, 4'($urandom_range(4, 15))};
        else if (pick < 17) hdr = {sdte_pkg::TYPE_HDR, 4'($urandom)};
        else hdr = 8'($urandom);
      end
      if ($urandom_range(0, 11) == 0) begin
        send_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end else if (s[0]) begin
        send_plain(num, hdr, 8'($urandom), 8'($urandom));
      end else begin
        send_plain(num, 8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    frame_in.valid <= 1'b0;
    frame_in.frame_number <= '0;
    frame_in.slow_in0 <= '0;
    frame_in.slow_in1 <= '0;
    frame_in.slow_in2 <= '0;
    sb = new(PUBLISH_AT);
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_frame(8'h00, 8'hFF, 8'hFF, 8'hFF);
    for (int p = 0; p < 4; p++) begin
      send_plain(8'(2 * p + 1), {sdte_pkg::TYPE_TXT, 4'(p)}, MSG[5 * p], MSG[5 * p + 1]);
      send_plain(8'(2 * p + 2), MSG[5 * p + 2], MSG[5 * p + 3], MSG[5 * p + 4]);
    end
    send_plain(8'h09, {sdte_pkg::TYPE_TXT, 4'h4}, 8'hAA, 8'hBB);
    send_plain(8'h0A, 8'hCC, 8'hDD, 8'hEE);
    send_plain(8'h0B, {sdte_pkg::TYPE_TXT, 4'hF}, 8'h11, 8'h22);
    send_plain(8'h0C, 8'h33, 8'h44, 8'h55);
    send_plain(8'h0D, {sdte_pkg::TYPE_HDR, 4'h0}, 8'h01, 8'h02);
    send_frame(8'h0E, 8'h00, 8'h00, 8'h00);
    send_plain(8'h0F, {sdte_pkg::TYPE_HDR, 4'hF}, 8'hFF, 8'hFF);
    send_plain(8'h11, 8'h30, 8'h5A, 8'hA5);
    send_frame(8'h12, 8'hFF, 8'hFF, 8'hFF);
    send_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_frame(8'h20, 8'h00, 8'h00, 8'h00);
    send_frame(8'h40, 8'h12, 8'h34, 8'h56);
    send_plain(8'h81, {sdte_pkg::TYPE_TXT, 4'h1}, 8'h00, 8'hFF);
    send_plain(8'hC2, 8'h7E, 8'h80, 8'h01);
    send_frame(8'h14, 8'h00, 8'h00, 8'h00);

    frame_in.valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    @(posedge clk);

    for (int n = 0; n < 19; n++) begin
      calm = ($urandom_range(0, 3) == 0);
      send_superframe();
    end

    calm = 1'b1;
    repeat (6) send_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    frame_in.valid <= 1'b0;

    while (sb.due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
